### rtl/ddr_pkg.sv
`timescale 1ns / 1ps

package ddr_pkg;

	localparam int MAX_PLACES = 32;
	localparam int DATA_W     = 31;
	localparam int PLACE_W    = 6;
	localparam int IDX_W      = $clog2(MAX_PLACES);
	localparam int VALUE_W    = 32;
	localparam int PROD_W     = DATA_W + 4;
	localparam int DIGIT_W    = 4;
	localparam int DIV_STEPS  = DATA_W;

	localparam logic [DIGIT_W-1:0] DIGIT_NINE = DIGIT_W'(9);

endpackage

### rtl/decimal_division_rounded_core.sv
// The integer part follows the 31-step bit-serial integer division, a step per place
// (multiply, four digit bits) and a rounding step; then one decimal digit per cycle.
// A zero divisor answers in the next cycle. One division runs at a time: a new start
// is taken only while the sequencer is idle.
// Reset (arst_n low, asynchronous) returns the sequencer to idle and drops valid.
// Results are strobed for one cycle each and the receiver cannot stall them.
`timescale 1ns / 1ps

module decimal_division_rounded_core
	import ddr_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [DATA_W-1:0]   dividend,
	input  logic [DATA_W-1:0]   divisor,
	input  logic [PLACE_W-1:0]  places,
	output logic                valid,
	output logic [VALUE_W-1:0]  value,
	output logic                is_integer_part,
	output logic                last,
	output logic                div_by_zero
);

	typedef enum logic [2:0] {
		IDLE,
		INT_DIV,
		DIG_MUL,
		DIG_BIT,
		ROUND,
		EMIT_INT,
		EMIT_DIG
	} state_t;

	state_t               state_q;
	logic [DATA_W-1:0]    rem_q;
	logic [DATA_W-1:0]    quo_q;
	logic [DATA_W-1:0]    den_q;
	logic [PLACE_W-1:0]   nplaces_q;
	logic [PLACE_W-1:0]   cnt_q;
	logic [1:0]           bit_q;
	logic [PROD_W-1:0]    t_q;
	logic [DIGIT_W-2:0]   acc_q;
	logic [IDX_W-1:0]     last_non9_q;
	logic                 have_non9_q;
	logic                 round_q;
	logic                 valid_q;
	logic [VALUE_W-1:0]   value_q;
	logic                 is_int_q;
	logic                 last_q;
	logic                 dz_q;

	logic [DIGIT_W-1:0]   digits_q [MAX_PLACES];

	logic [DATA_W:0]      div_r;
	logic [DATA_W:0]      div_diff;
	logic                 div_ge;
	logic [PROD_W-1:0]    shifted_den;
	logic                 dig_ge;
	logic [PROD_W-1:0]    dig_diff;
	logic [DIGIT_W-1:0]   new_digit;
	logic [PROD_W-1:0]    times_ten;
	logic                 round_up;
	logic [DIGIT_W-1:0]   rd_digit;
	logic [DIGIT_W-1:0]   out_digit;
	logic [PLACE_W-1:0]   cnt_next;
	logic                 accept;
	logic                 dig_we;

	assign accept = start && (state_q == IDLE);

	// One restoring step of the integer division.
	assign div_r    = {rem_q, quo_q[DATA_W-1]};
	assign div_ge   = div_r >= {1'b0, den_q};
	assign div_diff = div_r - {1'b0, den_q};

	// One quotient bit of the decimal digit, weights 8, 4, 2 and 1.
	assign shifted_den = PROD_W'(den_q) << bit_q;
	assign dig_ge      = t_q >= shifted_den;
	assign dig_diff    = t_q - shifted_den;
	assign new_digit   = {acc_q, dig_ge};

	assign times_ten = (PROD_W'(rem_q) << 3) + (PROD_W'(rem_q) << 1);

	// The digit after the last place is five or more exactly when twice the remainder
	// reaches the divisor.
	assign round_up = {rem_q, 1'b0} >= {1'b0, den_q};

	assign cnt_next = cnt_q + PLACE_W'(1);
	assign dig_we   = (state_q == DIG_BIT) && (bit_q == 2'd0);

	// Rounding lands on the last digit that is not a nine; the nines after it roll to
	// zero. With no such digit the carry reaches the integer part.
	assign rd_digit = digits_q[cnt_q[IDX_W-1:0]];
	always_comb begin
		out_digit = rd_digit;
		if (round_q) begin
			if (!have_non9_q) begin
				out_digit = '0;
			end else if (cnt_q[IDX_W-1:0] == last_non9_q) begin
				out_digit = rd_digit + DIGIT_W'(1);
			end else if (cnt_q[IDX_W-1:0] > last_non9_q) begin
				out_digit = '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dig_we) begin
			digits_q[cnt_q[IDX_W-1:0]] <= new_digit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			rem_q       <= '0;
			quo_q       <= '0;
			den_q       <= '0;
			nplaces_q   <= '0;
			cnt_q       <= '0;
			bit_q       <= '0;
			t_q         <= '0;
			acc_q       <= '0;
			last_non9_q <= '0;
			have_non9_q <= 1'b0;
			round_q     <= 1'b0;
			valid_q     <= 1'b0;
			value_q     <= '0;
			is_int_q    <= 1'b0;
			last_q      <= 1'b0;
			dz_q        <= 1'b0;
		end else begin
			valid_q <= 1'b0;
			unique case (state_q)
				IDLE: begin
					if (accept) begin
						if (divisor == '0) begin
							valid_q  <= 1'b1;
							value_q  <= '0;
							is_int_q <= 1'b0;
							last_q   <= 1'b1;
							dz_q     <= 1'b1;
						end else begin
							rem_q       <= '0;
							quo_q       <= dividend;
							den_q       <= divisor;
							nplaces_q   <= (places > PLACE_W'(MAX_PLACES)) ?
								PLACE_W'(MAX_PLACES) : places;
							cnt_q       <= '0;
							have_non9_q <= 1'b0;
							last_non9_q <= '0;
							state_q     <= INT_DIV;
						end
					end
				end
				INT_DIV: begin
					rem_q <= div_ge ? div_diff[DATA_W-1:0] : div_r[DATA_W-1:0];
					quo_q <= {quo_q[DATA_W-2:0], div_ge};
					if (cnt_q == PLACE_W'(DIV_STEPS - 1)) begin
						cnt_q   <= '0;
						state_q <= (nplaces_q == '0) ? ROUND : DIG_MUL;
					end else begin
						cnt_q <= cnt_next;
					end
				end
				DIG_MUL: begin
					t_q     <= times_ten;
					bit_q   <= 2'd3;
					acc_q   <= '0;
					state_q <= DIG_BIT;
				end
				DIG_BIT: begin
					if (dig_ge) begin
						t_q <= dig_diff;
					end
					acc_q <= new_digit[DIGIT_W-2:0];
					bit_q <= bit_q - 2'd1;
					if (bit_q == 2'd0) begin
						rem_q <= dig_ge ? dig_diff[DATA_W-1:0] : t_q[DATA_W-1:0];
						if (new_digit != DIGIT_NINE) begin
							have_non9_q <= 1'b1;
							last_non9_q <= cnt_q[IDX_W-1:0];
						end
						cnt_q   <= cnt_next;
						state_q <= (cnt_next == nplaces_q) ? ROUND : DIG_MUL;
					end
				end
				ROUND: begin
					round_q <= round_up;
					state_q <= EMIT_INT;
				end
				EMIT_INT: begin
					valid_q  <= 1'b1;
					value_q  <= {1'b0, quo_q} + VALUE_W'(round_q && !have_non9_q);
					is_int_q <= 1'b1;
					last_q   <= (nplaces_q == '0);
					dz_q     <= 1'b0;
					cnt_q    <= '0;
					state_q  <= (nplaces_q == '0) ? IDLE : EMIT_DIG;
				end
				EMIT_DIG: begin
					valid_q  <= 1'b1;
					value_q  <= VALUE_W'(out_digit);
					is_int_q <= 1'b0;
					last_q   <= (cnt_next == nplaces_q);
					dz_q     <= 1'b0;
					cnt_q    <= cnt_next;
					if (cnt_next == nplaces_q) begin
						state_q <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	assign busy            = (state_q != IDLE);
	assign valid           = valid_q;
	assign value           = value_q;
	assign is_integer_part = is_int_q;
	assign last            = last_q;
	assign div_by_zero     = dz_q;

`ifndef SYNTHESIS
	a_zero_div_answers: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (divisor == '0) |=> valid && div_by_zero && last)
		else $error("zero divisor did not answer in the next cycle");

	a_zero_div_value: assert property (@(posedge clk) disable iff (!arst_n)
		valid && div_by_zero |-> (value == '0) && !is_integer_part)
		else $error("zero divisor transfer carries a value");

	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !is_integer_part && !div_by_zero |-> value <= VALUE_W'(9))
		else $error("decimal digit out of range");

	a_int_part_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid && is_integer_part |-> !div_by_zero && (value <= (VALUE_W'(1) << DATA_W)))
		else $error("integer part out of range");

	a_last_ends_item: assert property (@(posedge clk) disable iff (!arst_n)
		valid && last |-> !busy)
		else $error("final transfer while the sequencer still runs");
`endif

endmodule
